[rtl/trcb_pkg.sv]
// Shared types, constants and helpers for the text row cell buffer.
// No dependencies; trcb_ctrl, the top level and the testbench import this package.
package trcb_pkg;

  // Default row capacity in cells
  localparam int DEF_MAX_COLS = 256;

  // Fixed field widths of the item and result beats
  localparam int CMD_W  = 3;
  localparam int COL_W  = 9;
  localparam int STAT_W = 2;
  localparam int CODE_W = 21;
  localparam int ATTR_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_FILL   = 3'd3,
    CMD_SHRINK = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_READ   = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              fragment;
    logic [ATTR_W-1:0] attributes;
  } cell_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [COL_W-1:0] column;
    logic [COL_W-1:0] target_length;
    cell_t            entry;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [COL_W-1:0] row_length;
    logic [COL_W-1:0] used_length;
    cell_t            entry;
  } result_t;

  // A cell counts towards the used length unless it is a blank non-fragment
  function automatic logic cell_busy(input cell_t c);
    return (c.code != '0) || c.fragment;
  endfunction

endpackage

[rtl/trcb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module trcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/trcb_ctrl.sv]
// Command sequencer for the text row cell buffer: owns the length, the used
// length and the cell RAM. Depends on trcb_pkg and trcb_ram.
module trcb_ctrl
  import trcb_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int LEN_W = $clog2(MAX_COLS + 1);
  localparam int AW    = $clog2(MAX_COLS);
  localparam int CW    = (LEN_W > COL_W) ? LEN_W : COL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_MV, S_PUT, S_REM_MV, S_FILL, S_RD_WAIT, S_SCAN_ST, S_SCAN, S_FINISH
  } state_t;

  state_t             state_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   used_r;
  logic [LEN_W-1:0]   ptr_r;
  logic [LEN_W-1:0]   col_r;
  logic               scan_r;
  cell_t              cell_r;
  cell_t              rd_cell_r;
  status_t            status_r;

  logic               accept;
  logic [CW-1:0]      colx, tgtx, lenx, usedx;
  logic [LEN_W-1:0]   col_l, col_p1, tgt_l;
  logic [LEN_W-1:0]   len_m1, ptr_m1, ptr_m2, ptr_p1, used_m1, used_m2;
  logic               full, busy_in;

  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  cell_t              mem_wd;
  logic [$bits(cell_t)-1:0] mem_rd;
  cell_t              rdata;

  trcb_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (MAX_COLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign rdata      = cell_t'(mem_rd);
  assign item_stall = (state_r != S_IDLE);
  assign accept     = item_valid && (state_r == S_IDLE);

  assign colx    = CW'(item.column);
  assign tgtx    = CW'(item.target_length);
  assign lenx    = CW'(len_r);
  assign usedx   = CW'(used_r);
  assign col_l   = colx[LEN_W-1:0];
  assign tgt_l   = tgtx[LEN_W-1:0];
  assign col_p1  = col_l + LEN_W'(1);
  assign len_m1  = len_r - LEN_W'(1);
  assign ptr_m1  = ptr_r - LEN_W'(1);
  assign ptr_m2  = ptr_r - LEN_W'(2);
  assign ptr_p1  = ptr_r + LEN_W'(1);
  assign used_m1 = used_r - LEN_W'(1);
  assign used_m2 = used_r - LEN_W'(2);
  assign full    = (len_r == LEN_W'(MAX_COLS));
  assign busy_in = cell_busy(item.entry);

  // Memory port steering
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r[AW-1:0];
    mem_wd = cell_r;
    mem_ra = '0;
    unique case (state_r)
      S_IDLE: begin
        unique case (cmd_e'(item.command))
          CMD_INSERT: mem_ra = len_m1[AW-1:0];
          CMD_REMOVE: mem_ra = col_p1[AW-1:0];
          CMD_READ:   mem_ra = col_l[AW-1:0];
          default:    mem_ra = '0;
        endcase
      end
      S_INS_MV: begin
        mem_we = 1'b1;
        mem_wd = rdata;
        mem_ra = ptr_m2[AW-1:0];
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = col_r[AW-1:0];
      end
      S_REM_MV: begin
        mem_we = 1'b1;
        mem_wa = ptr_m1[AW-1:0];
        mem_wd = rdata;
        mem_ra = ptr_p1[AW-1:0];
      end
      S_FILL:    mem_we = 1'b1;
      S_SCAN_ST: mem_ra = used_m1[AW-1:0];
      S_SCAN:    mem_ra = used_m2[AW-1:0];
      default:   mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      used_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            status_r  <= ST_OK;
            rd_cell_r <= '0;
            cell_r    <= item.entry;
            col_r     <= col_l;
            scan_r    <= 1'b0;
            state_r   <= S_FINISH;
            unique case (cmd_e'(item.command))
              CMD_INSERT: begin
                if (colx > lenx) begin
                  status_r <= ST_RANGE;
                end else if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  len_r <= len_r + LEN_W'(1);
                  if (col_l < used_r) begin
                    used_r <= used_r + LEN_W'(1);
                  end else if (busy_in) begin
                    used_r <= col_p1;
                  end
                  if (col_l == len_r) begin
                    state_r <= S_PUT;
                  end else begin
                    ptr_r   <= len_r;
                    state_r <= S_INS_MV;
                  end
                end
              end
              CMD_APPEND: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  len_r <= len_r + LEN_W'(1);
                  col_r <= len_r;
                  if (busy_in) begin
                    used_r <= len_r + LEN_W'(1);
                  end
                  state_r <= S_PUT;
                end
              end
              CMD_REMOVE: begin
                if (colx >= lenx) begin
                  status_r <= ST_RANGE;
                  if (len_r != '0) begin
                    len_r <= len_m1;
                    // last cell dropped: if it was in use, rescan below it
                    if (used_r == len_r) begin
                      used_r  <= len_m1;
                      state_r <= S_SCAN_ST;
                    end
                  end
                end else begin
                  len_r <= len_m1;
                  if (col_p1 < used_r) begin
                    used_r <= used_m1;
                  end else if (col_p1 == used_r) begin
                    used_r <= used_m1;
                    scan_r <= 1'b1;
                  end
                  if (col_p1 < len_r) begin
                    ptr_r   <= col_p1;
                    state_r <= S_REM_MV;
                  end else if (col_p1 == used_r) begin
                    state_r <= S_SCAN_ST;
                  end
                end
              end
              CMD_FILL: begin
                if (tgtx > lenx) begin
                  if (tgtx > CW'(MAX_COLS)) begin
                    status_r <= ST_FULL;
                  end else begin
                    ptr_r <= len_r;
                    len_r <= tgt_l;
                    if (busy_in) begin
                      used_r <= tgt_l;
                    end
                    state_r <= S_FILL;
                  end
                end
              end
              CMD_SHRINK: begin
                if (tgtx < lenx) begin
                  len_r <= tgt_l;
                  if (usedx > tgtx) begin
                    used_r  <= tgt_l;
                    state_r <= S_SCAN_ST;
                  end
                end
              end
              CMD_CLEAR: begin
                len_r  <= '0;
                used_r <= '0;
              end
              CMD_READ: begin
                if (colx < lenx) begin
                  state_r <= S_RD_WAIT;
                end else begin
                  status_r <= ST_RANGE;
                end
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        // shift right: move cell ptr-1 to ptr, walking down to the column
        S_INS_MV: begin
          if (ptr_m1 == col_r) begin
            state_r <= S_PUT;
          end else begin
            ptr_r <= ptr_m1;
          end
        end
        S_PUT: state_r <= S_FINISH;
        // shift left: move cell ptr to ptr-1 up to the new length
        S_REM_MV: begin
          if (ptr_r == len_r) begin
            state_r <= scan_r ? S_SCAN_ST : S_FINISH;
          end else begin
            ptr_r <= ptr_p1;
          end
        end
        S_FILL: begin
          if (ptr_p1 == len_r) begin
            state_r <= S_FINISH;
          end else begin
            ptr_r <= ptr_p1;
          end
        end
        S_RD_WAIT: begin
          rd_cell_r <= rdata;
          state_r   <= S_FINISH;
        end
        S_SCAN_ST: state_r <= (used_r == '0) ? S_FINISH : S_SCAN;
        // cell used-1 is on the read port; drop it while blank
        S_SCAN: begin
          if (cell_busy(rdata)) begin
            state_r <= S_FINISH;
          end else begin
            used_r <= used_m1;
            if (used_m1 == '0) begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res_valid       = (state_r == S_FINISH);
  assign res.status      = status_r;
  assign res.row_length  = lenx[COL_W-1:0];
  assign res.used_length = usedx[COL_W-1:0];
  assign res.entry       = rd_cell_r;

endmodule

[rtl/text_row_cell_buffer_unit.sv]
// Top level of the text row cell buffer: port packing and the result register.
// Depends on trcb_pkg and trcb_ctrl (which holds the cell RAM).
//
//   channel | direction | handshake         | beat carries
//   --------+-----------+-------------------+--------------------------------------
//   in_     | input     | in_valid/in_stall | command, column, target length, cell
//   out_    | output    | out_valid/out_stall | status, lengths, cell read
//
// Sequencing: one command at a time. Insert moves each cell from the column
// on one place right before it writes the new cell, remove moves each cell
// after the column one place left, and fill writes the new cells in order;
// one cell moves through the single RAM write port each cycle. Remove and
// shrink may add a backward scan for the used length, one cell per cycle,
// up to the old used length.
// Reset: synchronous, active low; empties the row at once, RAM is left as is.
// Stalls: a finished beat waits in the result register while the next
// command already runs; out_stall only holds the sequencer once a second
// result is ready.
module text_row_cell_buffer_unit
  import trcb_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [COL_W-1:0]  in_column,
  input  logic [COL_W-1:0]  in_target_length,
  input  logic [CODE_W-1:0] in_cell_code,
  input  logic              in_cell_fragment,
  input  logic [ATTR_W-1:0] in_cell_attributes,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [COL_W-1:0]  out_row_length,
  output logic [COL_W-1:0]  out_used_length,
  output logic [CODE_W-1:0] out_read_code,
  output logic              out_read_fragment,
  output logic [ATTR_W-1:0] out_read_attributes
);

  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    out_valid_r;
  result_t out_res_r;

  // Pack the input beat
  assign item.command          = in_command;
  assign item.column           = in_column;
  assign item.target_length    = in_target_length;
  assign item.entry.code       = in_cell_code;
  assign item.entry.fragment   = in_cell_fragment;
  assign item.entry.attributes = in_cell_attributes;

  trcb_ctrl #(
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_stall (in_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Load the result register when empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_row_length      = out_res_r.row_length;
  assign out_used_length     = out_res_r.used_length;
  assign out_read_code       = out_res_r.entry.code;
  assign out_read_fragment   = out_res_r.entry.fragment;
  assign out_read_attributes = out_res_r.entry.attributes;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_row_cell_buffer_unit: directed edge cases, then random row edits.
// Depends on trcb_pkg for widths, commands, status codes and the item/result/cell structs.
module testbench;
  import trcb_pkg::*;

  localparam int ROW_CELLS = DEF_MAX_COLS;
  localparam int RANDOM_ITEMS = 2000;
  // Worst case: a full-row shift plus a backward used-length scan, with margin
  localparam int DRAIN_CYCLES = 700;
  localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;
  // Command code the block has no operation for
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command = '0;
  logic [COL_W-1:0]  in_column = '0;
  logic [COL_W-1:0]  in_target_length = '0;
  logic [CODE_W-1:0] in_cell_code = '0;
  logic              in_cell_fragment = 1'b0;
  logic [ATTR_W-1:0] in_cell_attributes = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [COL_W-1:0]  out_row_length;
  logic [COL_W-1:0]  out_used_length;
  logic [CODE_W-1:0] out_read_code;
  logic              out_read_fragment;
  logic [ATTR_W-1:0] out_read_attributes;

  text_row_cell_buffer_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_column           (in_column),
    .in_target_length    (in_target_length),
    .in_cell_code        (in_cell_code),
    .in_cell_fragment    (in_cell_fragment),
    .in_cell_attributes  (in_cell_attributes),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_row_length      (out_row_length),
    .out_used_length     (out_used_length),
    .out_read_code       (out_read_code),
    .out_read_fragment   (out_read_fragment),
    .out_read_attributes (out_read_attributes)
  );

  // 12 ns period: 6 ns low, 6 ns high
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the row: cell contents and current length
  cell_t       row_cells [ROW_CELLS];
  int unsigned row_len;

  item_t   pending_items [$];   // commands not yet sent
  result_t row_results [$];     // results owed by the block, oldest first
  int      fault_count = 0;

  // Apply one command to the shadow row and return the beat the block must answer with.
  function automatic result_t apply_row_command(input item_t cmd);
    result_t     res;
    int unsigned col;
    int unsigned tgt;
    int unsigned i;
    int unsigned used;
    res = '0;
    res.status = ST_OK;
    col = cmd.column;
    tgt = cmd.target_length;
    case (cmd.command)
      CMD_INSERT: begin
        // Range is judged before fullness
        if (col > row_len) begin
          res.status = ST_RANGE;
        end else if (row_len >= ROW_CELLS) begin
          res.status = ST_FULL;
        end else begin
          for (i = row_len; i > col; i--) row_cells[i] = row_cells[i - 1];
          row_cells[col] = cmd.entry;
          row_len++;
        end
      end
      CMD_APPEND: begin
        if (row_len >= ROW_CELLS) begin
          res.status = ST_FULL;
        end else begin
          row_cells[row_len] = cmd.entry;
          row_len++;
        end
      end
      CMD_REMOVE: begin
        // Out of range still shortens a non-empty row; no cell moves
        if (col >= row_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = col + 1; i < row_len; i++) row_cells[i - 1] = row_cells[i];
        end
        if (row_len > 0) row_len--;
      end
      CMD_FILL: begin
        if (tgt > row_len) begin
          if (tgt > ROW_CELLS) begin
            res.status = ST_FULL;
          end else begin
            for (i = row_len; i < tgt; i++) row_cells[i] = cmd.entry;
            row_len = tgt;
          end
        end
      end
      CMD_SHRINK: begin
        if (tgt < row_len) row_len = tgt;
      end
      CMD_CLEAR: begin
        row_len = 0;
      end
      CMD_READ: begin
        if (col < row_len) res.entry = row_cells[col];
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    // Trim trailing blanks: zero code and not a fragment
    used = row_len;
    while (used > 0 && row_cells[used - 1].code == '0 && !row_cells[used - 1].fragment)
      used--;
    res.row_length = COL_W'(row_len);
    res.used_length = COL_W'(used);
    return res;
  endfunction

  function automatic cell_t make_cell(input logic [CODE_W-1:0] code, input logic frag,
                                      input logic [ATTR_W-1:0] attr);
    cell_t c;
    c.code = code;
    c.fragment = frag;
    c.attributes = attr;
    return c;
  endfunction

  // Blank cells are common so that trailing-blank trimming gets real work
  function automatic cell_t random_cell();
    logic [CODE_W-1:0] code;
    case ($urandom_range(0, 5))
      0, 1:    code = '0;
      2:       code = CODE_MAX;
      default: code = CODE_W'($urandom_range(0, 1114111));
    endcase
    return make_cell(code, $urandom_range(0, 3) == 0, $urandom);
  endfunction

  // Queue a command; step the shadow so that the generator can aim at the coming length
  task automatic queue_command(input logic [CMD_W-1:0] cmd, input int unsigned col,
                               input int unsigned tgt, input cell_t c);
    item_t   it;
    result_t discard;
    it.command = cmd;
    it.column = COL_W'(col);
    it.target_length = COL_W'(tgt);
    it.entry = c;
    discard = apply_row_command(it);
    pending_items.push_back(it);
  endtask

  task automatic check_field(input string field, input logic [ATTR_W-1:0] want,
                             input logic [ATTR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fault_count++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps
  int     burst_left = 1;
  int     gap_left = 0;
  item_t  item_on_bus;

  always @(posedge clk) begin : driver
    logic taken;
    taken = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict at the moment the block takes the beat
      if (taken) row_results.push_back(apply_row_command(item_on_bus));
      if (!in_valid || taken) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item_on_bus = pending_items.pop_front();
          in_valid <= 1'b1;
          in_command <= item_on_bus.command;
          in_column <= item_on_bus.column;
          in_target_length <= item_on_bus.target_length;
          in_cell_code <= item_on_bus.entry.code;
          in_cell_fragment <= item_on_bus.entry.fragment;
          in_cell_attributes <= item_on_bus.entry.attributes;
          // End of burst: draw the next gap, often none at all
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall style is redrawn whenever its phase counter runs out
  int stall_style = 0;
  int stall_phase = 0;
  int cycle_count = 0;

  always @(posedge clk) begin : monitor
    result_t want;
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      if (row_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        fault_count++;
      end else begin
        want = row_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("row_length", want.row_length, out_row_length);
        check_field("used_length", want.used_length, out_used_length);
        check_field("read_code", want.entry.code, out_read_code);
        check_field("read_fragment", want.entry.fragment, out_read_fragment);
        check_field("read_attributes", want.entry.attributes, out_read_attributes);
      end
    end
    if (stall_phase == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_phase = $urandom_range(50, 400);
    end else begin
      stall_phase--;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycle_count % 8) < 5;
    endcase
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned len;
    int          pick;
    int          n;
    for (n = 0; n < ROW_CELLS; n++) row_cells[n] = '0;
    row_len = 0;

    // Empty row: read, remove and insert beyond length, no-op shrink and fill
    queue_command(CMD_READ, 0, 0, random_cell());
    queue_command(CMD_REMOVE, 0, 0, random_cell());
    queue_command(CMD_INSERT, 1, 0, random_cell());
    queue_command(CMD_SHRINK, 0, 0, random_cell());
    queue_command(CMD_FILL, 0, 0, random_cell());
    // Field extremes, insert at front and at the very end
    queue_command(CMD_APPEND, 0, 0, make_cell(CODE_MAX, 1'b1, '1));
    queue_command(CMD_INSERT, 0, 0, make_cell('0, 1'b0, '0));
    queue_command(CMD_INSERT, 2, 0, make_cell('0, 1'b1, 32'h5A5A_A5A5));
    // Pad with blanks so the used length falls short of the row length
    queue_command(CMD_FILL, 0, 5, make_cell('0, 1'b0, 32'hDEAD_0001));
    queue_command(CMD_READ, 0, 0, random_cell());
    queue_command(CMD_READ, 4, 0, random_cell());
    queue_command(CMD_READ, 5, 0, random_cell());
    // Remove beyond length still shortens the row
    queue_command(CMD_REMOVE, 9, 0, random_cell());
    queue_command(CMD_REMOVE, 0, 0, random_cell());
    queue_command(CMD_UNUSED, 511, 511, make_cell('1, 1'b1, '1));
    // Fill past capacity, then to exactly full
    queue_command(CMD_FILL, 0, ROW_CELLS + 1, random_cell());
    queue_command(CMD_FILL, 0, 511, random_cell());
    queue_command(CMD_FILL, 0, ROW_CELLS, make_cell(21'h00041, 1'b0, 32'h1234_5678));
    queue_command(CMD_APPEND, 0, 0, random_cell());
    queue_command(CMD_INSERT, ROW_CELLS, 0, random_cell());
    queue_command(CMD_INSERT, 300, 0, random_cell());
    queue_command(CMD_READ, ROW_CELLS - 1, 0, random_cell());
    queue_command(CMD_READ, ROW_CELLS, 0, random_cell());
    queue_command(CMD_REMOVE, ROW_CELLS - 1, 0, random_cell());
    queue_command(CMD_SHRINK, 0, 511, random_cell());
    queue_command(CMD_SHRINK, 0, 3, random_cell());
    queue_command(CMD_CLEAR, 0, 0, random_cell());

    // Random edits: mostly in-range commands that keep the row busy, some noise
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      len = row_len;
      pick = $urandom_range(0, 99);
      if (pick < 16)
        queue_command(CMD_INSERT, $urandom_range(0, len), 0, random_cell());
      else if (pick < 24)
        queue_command(CMD_APPEND, 0, 0, random_cell());
      else if (pick < 44)
        queue_command(CMD_REMOVE, (len == 0) ? 0 : $urandom_range(0, len - 1), 0,
                      random_cell());
      else if (pick < 62)
        queue_command(CMD_READ, (len == 0) ? 0 : $urandom_range(0, len - 1), 0,
                      random_cell());
      else if (pick < 68)
        queue_command(CMD_FILL, 0, $urandom_range(len, (len + 40 > ROW_CELLS) ?
                      ROW_CELLS : len + 40), random_cell());
      else if (pick < 71)
        // Run the row up to or near capacity
        queue_command(CMD_FILL, 0, $urandom_range(ROW_CELLS - 16, ROW_CELLS), random_cell());
      else if (pick < 77)
        queue_command(CMD_SHRINK, 0, $urandom_range(0, len), random_cell());
      else if (pick < 80)
        queue_command(CMD_CLEAR, 0, 0, random_cell());
      else
        // Any code, any column, any target
        queue_command(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 511),
                      $urandom_range(0, 511), random_cell());
    end

    // Start the block from an empty row
    for (n = 0; n < ROW_CELLS; n++) row_cells[n] = '0;
    row_len = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (row_results.size() != 0) @(posedge clk);
    // Hold for a stray late beat
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && row_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: ends the run as a failure if it has not finished by then
  initial begin
    #(100_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
rtl/trcb_pkg.sv
rtl/trcb_ram.sv
rtl/trcb_ctrl.sv
rtl/text_row_cell_buffer_unit.sv
test/testbench.sv
